[sv/ordered_list_engine_top_defines.svh]
// Assertion macros for the checker of the ordered list engine.
`ifndef ORDERED_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_LIST_ENGINE_TOP_DEFINES_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define OLE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold at the clock edge after the antecedent.
`define OLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ole_pkg.sv]
// Shared types and constants of the ordered list engine.
package ole_pkg;

   // Field widths of the item channels.
   localparam int MODE_W   = 3;
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   // Request operations.
   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT   = 3'd0,
      MODE_APPEND   = 3'd1,
      MODE_DELETE   = 3'd2,
      MODE_DEL_LAST = 3'd3,
      MODE_RETRIEVE = 3'd4,
      MODE_LOCATE   = 3'd5,
      MODE_CLEAR    = 3'd6
   } mode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Read address selection.
   typedef enum logic [1:0] {
      RD_AT    = 2'd0,
      RD_BELOW = 2'd1,
      RD_ABOVE = 2'd2,
      RD_POS   = 2'd3
   } rd_sel_type;

   // Walking index update.
   typedef enum logic [2:0] {
      IDX_HOLD  = 3'd0,
      IDX_COUNT = 3'd1,
      IDX_POS   = 3'd2,
      IDX_ZERO  = 3'd3,
      IDX_DEC   = 3'd4,
      IDX_INC   = 3'd5
   } idx_op_type;

   // Entry count update.
   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } cnt_op_type;

   // Result selection.
   typedef enum logic [2:0] {
      RES_OK    = 3'd0,
      RES_RANGE = 3'd1,
      RES_MISS  = 3'd2,
      RES_FULL  = 3'd3,
      RES_READ  = 3'd4,
      RES_FOUND = 3'd5
   } res_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch;
      logic       rd_en;
      rd_sel_type rd_sel;
      idx_op_type idx_op;
      logic       wr_shift;
      logic       wr_value;
      cnt_op_type cnt_op;
      logic       res_load;
      res_type    res_sel;
      logic       out_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      mode_type mode;
      logic     pos_gt_count;
      logic     pos_lt_count;
      logic     pos_is_last;
      logic     full;
      logic     count_zero;
      logic     up_last;
      logic     down_last;
      logic     idx_lt_count;
      logic     pend;
      logic     match;
      logic     out_free;
   } dp_status_type;

endpackage

[sv/ole_req_if.sv]
// Request channel of the ordered list engine.
interface ole_req_if import ole_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, mode, position, value, input ready);
   modport sink (input valid, mode, position, value, output ready);
endinterface

[sv/ole_rsp_if.sv]
// Response channel of the ordered list engine.
interface ole_rsp_if import ole_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] data_out;
   logic [LEN_W-1:0]         length;

   modport source (output valid, status, data_out, length, input ready);
   modport sink (input valid, status, data_out, length, output ready);
endinterface

[sv/ole_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ole_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ole_ctrl.sv]
// Controller state machine of the ordered list engine.
module ole_ctrl import ole_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type sts,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b0_0000_0001,
      ST_DECODE     = 9'b0_0000_0010,
      ST_UP_SHIFT   = 9'b0_0000_0100,
      ST_DOWN_SHIFT = 9'b0_0000_1000,
      ST_FLUSH      = 9'b0_0001_0000,
      ST_PUT        = 9'b0_0010_0000,
      ST_READ       = 9'b0_0100_0000,
      ST_SCAN       = 9'b0_1000_0000,
      ST_RESULT     = 9'b1_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      is_insert;

   assign is_insert = (sts.mode == MODE_INSERT) || (sts.mode == MODE_APPEND);
   assign req_ready = (state_ff == ST_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.res_load = 1'b1;
            state_in     = ST_RESULT;
            case (sts.mode)
               MODE_INSERT, MODE_APPEND: begin
                  if (sts.pos_gt_count) begin
                     cmd.res_sel = RES_RANGE;
                  end else if (sts.full) begin
                     cmd.res_sel = RES_FULL;
                  end else if (sts.pos_lt_count) begin
                     cmd.res_load = 1'b0;
                     cmd.idx_op   = IDX_COUNT;
                     state_in     = ST_UP_SHIFT;
                  end else begin
                     cmd.res_load = 1'b0;
                     state_in     = ST_PUT;
                  end
               end
               MODE_DELETE: begin
                  if (!sts.pos_lt_count) begin
                     cmd.res_sel = RES_RANGE;
                  end else if (sts.pos_is_last) begin
                     cmd.cnt_op  = CNT_DEC;
                     cmd.res_sel = RES_OK;
                  end else begin
                     cmd.res_load = 1'b0;
                     cmd.idx_op   = IDX_POS;
                     state_in     = ST_DOWN_SHIFT;
                  end
               end
               MODE_DEL_LAST: begin
                  if (sts.count_zero) begin
                     cmd.res_sel = RES_RANGE;
                  end else begin
                     cmd.cnt_op  = CNT_DEC;
                     cmd.res_sel = RES_OK;
                  end
               end
               MODE_RETRIEVE: begin
                  if (sts.pos_lt_count) begin
                     cmd.res_load = 1'b0;
                     cmd.rd_en    = 1'b1;
                     cmd.rd_sel   = RD_POS;
                     state_in     = ST_READ;
                  end else begin
                     cmd.res_sel = RES_MISS;
                  end
               end
               MODE_LOCATE: begin
                  cmd.res_load = 1'b0;
                  cmd.idx_op   = IDX_ZERO;
                  state_in     = ST_SCAN;
               end
               MODE_CLEAR: begin
                  cmd.cnt_op  = CNT_CLEAR;
                  cmd.res_sel = RES_OK;
               end
               default: begin
                  cmd.res_sel = RES_RANGE;
               end
            endcase
         end
         ST_UP_SHIFT: begin
            // Read the entry below the index; the previous read lands one slot up.
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_BELOW;
            cmd.idx_op   = IDX_DEC;
            cmd.wr_shift = 1'b1;
            if (sts.up_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_DOWN_SHIFT: begin
            // Read the entry above the index; the previous read lands one slot down.
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_ABOVE;
            cmd.idx_op   = IDX_INC;
            cmd.wr_shift = 1'b1;
            if (sts.down_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            cmd.wr_shift = 1'b1;
            if (is_insert) begin
               state_in = ST_PUT;
            end else begin
               cmd.cnt_op   = CNT_DEC;
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_OK;
               state_in     = ST_RESULT;
            end
         end
         ST_PUT: begin
            cmd.wr_value = 1'b1;
            cmd.cnt_op   = CNT_INC;
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_OK;
            state_in     = ST_RESULT;
         end
         ST_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_READ;
            state_in     = ST_RESULT;
         end
         ST_SCAN: begin
            // Stream reads from the head and compare each one in the cycle after its read.
            cmd.rd_en  = sts.idx_lt_count;
            cmd.idx_op = sts.idx_lt_count ? IDX_INC : IDX_HOLD;
            if (sts.match) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FOUND;
               state_in     = ST_RESULT;
            end else if (!sts.idx_lt_count && !sts.pend) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_MISS;
               state_in     = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/ole_datapath.sv]
// Datapath of the ordered list engine: request latch, count, index, RAM and results.
module ole_datapath import ole_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ctrl_cmd_type             cmd,
   output dp_status_type            sts,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [DATA_W-1:0] rsp_data_out,
   output logic [LEN_W-1:0]         rsp_length
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int XW    = CMP_W + 1;

   mode_type                 mode_ff;
   logic [CMP_W-1:0]         pos_ff;
   logic [VALUE_WIDTH-1:0]   value_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         idx_ff;
   logic [CNT_W-1:0]         idx_in;
   logic                     pend_ff;
   logic [AW-1:0]            waddr_ff;
   status_type               res_status_ff;
   logic signed [DATA_W-1:0] res_data_ff;
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [LEN_W-1:0]         rsp_length_ff;

   logic [CMP_W-1:0]         count_ext;
   logic [CNT_W-1:0]         idx_below;
   logic [CNT_W-1:0]         idx_above;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [VALUE_WIDTH-1:0]   wr_data;
   logic [VALUE_WIDTH-1:0]   rd_data;
   logic signed [DATA_W-1:0] rd_ext;

   assign count_ext = CMP_W'(count_ff);
   assign idx_below = idx_ff - CNT_W'(1);
   assign idx_above = idx_ff + CNT_W'(1);
   assign rd_ext    = DATA_W'($signed(rd_data));

   // Read address selection.
   always_comb begin
      case (cmd.rd_sel)
         RD_BELOW: rd_addr = idx_below[AW-1:0];
         RD_ABOVE: rd_addr = idx_above[AW-1:0];
         RD_POS:   rd_addr = pos_ff[AW-1:0];
         default:  rd_addr = idx_ff[AW-1:0];
      endcase
   end

   // Write port: a shifted entry or the new value at its position.
   assign wr_en   = (cmd.wr_shift && pend_ff) || cmd.wr_value;
   assign wr_addr = cmd.wr_value ? pos_ff[AW-1:0] : waddr_ff;
   assign wr_data = cmd.wr_value ? value_ff : rd_data;

   ole_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ole_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Status back to the controller.
   always_comb begin
      sts.mode         = mode_ff;
      sts.pos_gt_count = pos_ff > count_ext;
      sts.pos_lt_count = pos_ff < count_ext;
      sts.pos_is_last  = (XW'(pos_ff) + XW'(1)) == XW'(count_ff);
      sts.full         = count_ff == CNT_W'(CAPACITY);
      sts.count_zero   = count_ff == '0;
      sts.up_last      = XW'(idx_ff) == (XW'(pos_ff) + XW'(1));
      sts.down_last    = (XW'(idx_ff) + XW'(2)) == XW'(count_ff);
      sts.idx_lt_count = idx_ff < count_ff;
      sts.pend         = pend_ff;
      sts.match        = pend_ff && (rd_data == value_ff);
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

   // Count and index updates.
   always_comb begin
      case (cmd.cnt_op)
         CNT_INC:   count_in = count_ff + CNT_W'(1);
         CNT_DEC:   count_in = count_ff - CNT_W'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
      case (cmd.idx_op)
         IDX_COUNT: idx_in = count_ff;
         IDX_POS:   idx_in = CNT_W'(pos_ff);
         IDX_ZERO:  idx_in = '0;
         IDX_DEC:   idx_in = idx_below;
         IDX_INC:   idx_in = idx_above;
         default:   idx_in = idx_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= cmd.rd_en;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request latch, read tag and result registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff  <= mode_type'(req_mode);
         pos_ff   <= (req_mode == MODE_APPEND) ? count_ext : CMP_W'(req_position);
         value_ff <= VALUE_WIDTH'(req_value);
      end
      if (cmd.rd_en) begin
         waddr_ff <= idx_ff[AW-1:0];
      end
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_RANGE: begin
               res_status_ff <= STATUS_MISS;
               res_data_ff   <= '0;
            end
            RES_MISS: begin
               res_status_ff <= STATUS_MISS;
               res_data_ff   <= '1;
            end
            RES_FULL: begin
               res_status_ff <= STATUS_FULL;
               res_data_ff   <= '0;
            end
            RES_READ: begin
               res_status_ff <= STATUS_OK;
               res_data_ff   <= rd_ext;
            end
            RES_FOUND: begin
               res_status_ff <= STATUS_OK;
               res_data_ff   <= DATA_W'(waddr_ff);
            end
            default: begin
               res_status_ff <= STATUS_OK;
               res_data_ff   <= '0;
            end
         endcase
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_length_ff <= count_ext[LEN_W-1:0];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_length   = rsp_length_ff;

endmodule

[sv/ordered_list_engine_top.sv]
// Ordered list engine: a list of up to CAPACITY signed values kept in a RAM by position.
// Each request item on req_ch (mode, position, value) gives exactly one response item on
// rsp_ch (status, data_out, length), in order. Both channels move an item on a clock edge
// where valid and ready are both high.
// Requests are handled one at a time. Operations that only check or change the length
// go from decode straight to the result; retrieve and an insert that moves no entry
// take one more step (a RAM read or the write of the value); an insert or a delete that
// moves entries shifts them one slot at a time, and a locate compares entries from the
// head until the first match or the end of the list.
// The time taken is set by the single RAM port pair: moving or comparing one entry per cycle.
// req_ch.ready comes back the cycle after the response is loaded.
// A finished response waits in the output register; the next request is accepted and
// worked on meanwhile, and only its own response waits for the register to free up.
// Synchronous reset empties the list and drops any pending response; RAM contents are
// not cleared, and entries at or past the length are never read.
module ordered_list_engine_top import ole_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   ole_req_if.sink    req_ch,
   ole_rsp_if.source  rsp_ch
);

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   // Sequencing of each request.
   ole_ctrl u_ole_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Storage, compare and result logic.
   ole_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ole_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_mode     (req_ch.mode),
      .req_position (req_ch.position),
      .req_value    (req_ch.value),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_status   (rsp_ch.status),
      .rsp_data_out (rsp_ch.data_out),
      .rsp_length   (rsp_ch.length)
   );

endmodule

[sv/ole_checker.sv]
// Port-level checker of the ordered list engine and its bind to the top level.
`include "ordered_list_engine_top_defines.svh"

module ole_checker import ole_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic signed [DATA_W-1:0] rsp_data_out,
   input logic [LEN_W-1:0]         rsp_length
);

   // One item at a time: ready drops once an item is taken.
   `OLE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after an item was accepted")

   // A stalled response item holds its value.
   `OLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_out) && $stable(rsp_length), "stalled response item changed")

   // A full rejection reports the full length and no data.
   `OLE_ASSERT_SAME(a_full_status, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), (rsp_length == LEN_W'(CAPACITY)) && (rsp_data_out == '0), "full status with wrong length or data")

   // Reset drops any pending response.
   `OLE_ASSERT_SAME(a_reset_clears, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")

endmodule

bind ordered_list_engine_top ole_checker #(
   .CAPACITY (CAPACITY)
) u_ole_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_data_out (rsp_ch.data_out),
   .rsp_length   (rsp_ch.length)
);

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the ordered list engine, with its scoreboard class.
import ole_pkg::*;

// One response item as the engine should return it.
typedef struct {
   status_type               status;
   logic signed [DATA_W-1:0] data;
   logic [LEN_W-1:0]         length;
} list_reply_type;

// Keeps a copy of the list and the responses still owed by the engine.
class list_scoreboard;
   int                       depth;
   int                       count;
   int                       mismatches;
   logic signed [DATA_W-1:0] slots[];
   list_reply_type           replies[$];

   function new(int depth_in);
      depth      = depth_in;
      slots      = new[depth_in];
      count      = 0;
      mismatches = 0;
   endfunction

   function int pending_count();
      return replies.size();
   endfunction

   function int list_length();
      return count;
   endfunction

   function logic signed [DATA_W-1:0] value_at(int at);
      return slots[at];
   endfunction

   // Insert before position at; the entries from there on move up by one.
   function status_type insert_at(int at, logic signed [DATA_W-1:0] val);
      int i;
      if (at > count) return STATUS_MISS;
      if (count >= depth) return STATUS_FULL;
      for (i = count; i > at; i--) slots[i] = slots[i - 1];
      slots[at] = val;
      count++;
      return STATUS_OK;
   endfunction

   // Remove position at; the entries after it move down by one.
   function status_type delete_at(int at);
      int i;
      if (at >= count) return STATUS_MISS;
      for (i = at; i + 1 < count; i++) slots[i] = slots[i + 1];
      count--;
      return STATUS_OK;
   endfunction

   // Apply an accepted request to the list and queue the response it should give.
   function void note_request(logic [MODE_W-1:0] op, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] val);
      list_reply_type r;
      bit             found;
      int             i;
      r.status = STATUS_OK;
      r.data   = '0;
      case (op)
         MODE_INSERT: r.status = insert_at(int'(pos), val);
         MODE_APPEND: r.status = insert_at(count, val);
         MODE_DELETE: r.status = delete_at(int'(pos));
         MODE_DEL_LAST: begin
            if (count == 0) r.status = STATUS_MISS;
            else count--;
         end
         MODE_RETRIEVE: begin
            if (int'(pos) < count) begin
               r.data = slots[pos];
            end else begin
               r.status = STATUS_MISS;
               r.data   = '1;
            end
         end
         MODE_LOCATE: begin
            // The first position holding the value wins.
            found    = 1'b0;
            r.status = STATUS_MISS;
            r.data   = '1;
            for (i = 0; i < count; i++) begin
               if (!found && slots[i] == val) begin
                  found    = 1'b1;
                  r.status = STATUS_OK;
                  r.data   = i;
               end
            end
         end
         MODE_CLEAR: count = 0;
         default: r.status = STATUS_MISS;
      endcase
      r.length = LEN_W'(count);
      replies.push_back(r);
   endfunction

   // Print one line per mismatch and count it.
   task report(string what, longint got, longint want);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Compare one accepted response item with the oldest expectation.
   task check_reply(logic [STATUS_W-1:0] status, logic signed [DATA_W-1:0] data,
                    logic [LEN_W-1:0] length);
      list_reply_type r;
      if (replies.size() == 0) begin
         report("response with no request pending", longint'(status), -1);
      end else begin
         r = replies.pop_front();
         if (status !== r.status) report("status", longint'(status), longint'(r.status));
         if (data !== r.data) report("data_out", longint'(data), longint'(r.data));
         if (length !== r.length) report("length", longint'(length), longint'(r.length));
      end
   endtask
endclass

module testbench;

   localparam int                CLOCK_PERIOD = 10;
   localparam int                LIST_DEPTH   = 16;
   localparam int                IDLE_PERCENT = 29;
   localparam int                RANDOM_ITEMS = 1300;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 3'd7;

   logic           clock  = 1'b0;
   logic           reset  = 1'b1;
   logic           steady = 1'b0;
   list_scoreboard sb     = new(LIST_DEPTH);

   ole_req_if req_if ();
   ole_rsp_if rsp_if ();

   ordered_list_engine_top #(
      .CAPACITY    (LIST_DEPTH),
      .VALUE_WIDTH (DATA_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Hard limit on the run time.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // Response side: random back-pressure, every accepted item is checked.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_reply(rsp_if.status, rsp_if.data_out, rsp_if.length);
      end
   end

   // Offer one request item, with random idle cycles first; returns at a falling edge.
   task automatic send_request(input logic [MODE_W-1:0] op, input int pos,
                               input logic signed [DATA_W-1:0] val);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.mode     <= op;
      req_if.position <= POS_W'(pos);
      req_if.value    <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(op, POS_W'(pos), val);
      @(negedge clock);
   endtask

   // Hold off new requests until every response has come back.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
   endtask

   // Mix of field extremes, a few small values that repeat, and wide random values.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(DATA_W - 1){1'b1}}};
         1: return {1'b1, {(DATA_W - 1){1'b0}}};
         2: return '1;
         3, 4, 5: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   // Growing phases favor inserts, shrinking phases favor deletes.
   function automatic logic [MODE_W-1:0] pick_op(bit grow);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < (grow ? 28 : 10)) return MODE_INSERT;
      if (pick < (grow ? 52 : 18)) return MODE_APPEND;
      if (pick < (grow ? 60 : 44)) return MODE_DELETE;
      if (pick < (grow ? 67 : 64)) return MODE_DEL_LAST;
      if (pick < 80) return MODE_RETRIEVE;
      if (pick < 97) return MODE_LOCATE;
      if (pick < 99) return MODE_CLEAR;
      return MODE_UNUSED;
   endfunction

   // Mostly positions in range for the current length, sometimes anywhere.
   function automatic int pick_position(logic [MODE_W-1:0] op, int len);
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, LIST_DEPTH);
      if (op == MODE_INSERT) return $urandom_range(0, len);
      if (len == 0) return $urandom_range(0, LIST_DEPTH);
      return $urandom_range(0, len - 1);
   endfunction

   // Stimulus and end of run.
   initial begin
      int                       n;
      int                       len;
      logic [MODE_W-1:0]        op;
      logic signed [DATA_W-1:0] val;

      req_if.valid    = 1'b0;
      req_if.mode     = MODE_INSERT;
      req_if.position = '0;
      req_if.value    = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Both deletes, retrieve and locate on an empty list miss; insert past the end too.
      send_request(MODE_DEL_LAST, 0, 0);
      send_request(MODE_DELETE, 0, 0);
      send_request(MODE_RETRIEVE, 0, 0);
      send_request(MODE_LOCATE, 0, 5);
      send_request(MODE_INSERT, 1, 5);

      // Build the list with the value extremes, then fill it up.
      send_request(MODE_INSERT, 0, {1'b0, {(DATA_W - 1){1'b1}}});
      send_request(MODE_APPEND, 0, {1'b1, {(DATA_W - 1){1'b0}}});
      send_request(MODE_INSERT, 1, -1);
      for (n = 1; n <= LIST_DEPTH - 3; n++) send_request(MODE_APPEND, 0, n * 1000);

      // Full list, reads of the last entry and past the end, misses, removals and the unused mode.
      send_request(MODE_INSERT, LIST_DEPTH, 7);
      send_request(MODE_APPEND, 0, 7);
      send_request(MODE_RETRIEVE, LIST_DEPTH - 1, 0);
      send_request(MODE_RETRIEVE, LIST_DEPTH, 0);
      send_request(MODE_LOCATE, 0, {1'b1, {(DATA_W - 1){1'b0}}});
      send_request(MODE_LOCATE, 0, 0);
      send_request(MODE_DELETE, LIST_DEPTH, 0);
      send_request(MODE_DELETE, 0, 0);
      send_request(MODE_DEL_LAST, 0, 0);
      send_request(MODE_UNUSED, 3, 3);
      send_request(MODE_CLEAR, 0, 0);
      send_request(MODE_RETRIEVE, 0, 0);
      wait_for_drain();

      // Random requests, with a stretch without idling and one full drain.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 500);
         if (n == 700) wait_for_drain();
         len = sb.list_length();
         op  = pick_op(((n / 120) % 2) == 0);
         if (op == MODE_LOCATE && len > 0 && $urandom_range(0, 9) < 6)
            val = sb.value_at($urandom_range(0, len - 1));
         else
            val = pick_value();
         send_request(op, pick_position(op, len), val);
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (4 * LIST_DEPTH) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_count() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/ole_pkg.sv
sv/ole_req_if.sv
sv/ole_rsp_if.sv
sv/ole_ram.sv
sv/ole_ctrl.sv
sv/ole_datapath.sv
sv/ordered_list_engine_top.sv
sv/ole_checker.sv
sim/testbench.sv
